FILE: design/mck_pkg.sv
// shared types, constants and lookup tables of the morse code keyer
package mck_pkg;

  localparam int unsigned CHAR_W    = 8;
  localparam int unsigned FREQ_W    = 12;
  localparam int unsigned DUR_W     = 11;
  localparam int unsigned WPM_W     = 5;
  localparam int unsigned DOT_W     = 8;
  localparam int unsigned COUNT_W   = 3;
  localparam int unsigned PATTERN_W = 7;
  localparam int unsigned ROM_IDX_W = 6;
  localparam int unsigned CFG_IDX_W = 1;
  localparam int unsigned CFG_DATA_W = 12;

  localparam logic [CFG_IDX_W-1:0] REG_WPM  = 1'b0;
  localparam logic [CFG_IDX_W-1:0] REG_TONE = 1'b1;

  localparam logic [WPM_W-1:0]  WPM_RESET  = 5'd20;
  localparam logic [FREQ_W-1:0] TONE_RESET = 12'd800;

  localparam logic [CHAR_W-1:0] CHAR_SPACE   = 8'h20;
  localparam logic [CHAR_W-1:0] CHAR_UPPER_Z = 8'h5A;
  localparam logic [CHAR_W-1:0] CHAR_LOWER_A = 8'h61;
  localparam logic [CHAR_W-1:0] CHAR_LOWER_Z = 8'h7A;
  localparam logic [CHAR_W-1:0] CASE_OFFSET  = 8'h20;
  localparam logic [CHAR_W-1:0] ROM_BASE     = 8'h20;

  typedef enum logic [1:0] {
    SEG_TONE,
    SEG_GAP,
    SEG_END,
    SEG_WORD
  } seg_kind_t;

  typedef struct packed {
    logic [COUNT_W-1:0]   count;
    logic [PATTERN_W-1:0] pattern;
  } symbol_t;

  typedef struct packed {
    logic      load_char;
    logic      load_seg;
    seg_kind_t kind;
    logic      advance;
  } cmd_t;

  typedef struct packed {
    logic code_ok;
    logic is_space;
    logic new_count_zero;
    logic count_one;
  } status_t;

  function automatic logic [DOT_W-1:0] dot_time(input logic [WPM_W-1:0] wpm);
    logic [DOT_W-1:0] d;
    case (wpm)
      5'd6:    d = 8'd150;
      5'd7:    d = 8'd128;
      5'd8:    d = 8'd112;
      5'd9:    d = 8'd100;
      5'd10:   d = 8'd90;
      5'd11:   d = 8'd81;
      5'd12:   d = 8'd75;
      5'd13:   d = 8'd69;
      5'd14:   d = 8'd64;
      5'd15:   d = 8'd60;
      5'd16:   d = 8'd56;
      5'd17:   d = 8'd52;
      5'd18:   d = 8'd50;
      5'd19:   d = 8'd47;
      5'd0, 5'd1, 5'd2, 5'd3, 5'd4, 5'd5: d = 8'd180;
      default: d = 8'd45;
    endcase
    return d;
  endfunction

  function automatic symbol_t symbol_lookup(input logic [ROM_IDX_W-1:0] idx);
    symbol_t s;
    case (idx)
      6'd2:  s = '{3'd6, 7'd18};
      6'd4:  s = '{3'd7, 7'd72};
      6'd7:  s = '{3'd6, 7'd30};
      6'd8:  s = '{3'd5, 7'd13};
      6'd9:  s = '{3'd6, 7'd29};
      6'd11: s = '{3'd5, 7'd10};
      6'd12: s = '{3'd6, 7'd51};
      6'd13: s = '{3'd6, 7'd33};
      6'd14: s = '{3'd6, 7'd42};
      6'd15: s = '{3'd5, 7'd9};
      6'd16: s = '{3'd5, 7'd31};
      6'd17: s = '{3'd5, 7'd30};
      6'd18: s = '{3'd5, 7'd28};
      6'd19: s = '{3'd5, 7'd24};
      6'd20: s = '{3'd5, 7'd16};
      6'd21: s = '{3'd5, 7'd0};
      6'd22: s = '{3'd5, 7'd1};
      6'd23: s = '{3'd5, 7'd3};
      6'd24: s = '{3'd5, 7'd7};
      6'd25: s = '{3'd5, 7'd15};
      6'd26: s = '{3'd6, 7'd7};
      6'd27: s = '{3'd6, 7'd21};
      6'd29: s = '{3'd5, 7'd33};
      6'd31: s = '{3'd6, 7'd12};
      6'd33: s = '{3'd2, 7'd2};
      6'd34: s = '{3'd4, 7'd1};
      6'd35: s = '{3'd4, 7'd5};
      6'd36: s = '{3'd3, 7'd1};
      6'd37: s = '{3'd1, 7'd0};
      6'd38: s = '{3'd4, 7'd4};
      6'd39: s = '{3'd3, 7'd3};
      6'd40: s = '{3'd4, 7'd0};
      6'd41: s = '{3'd2, 7'd0};
      6'd42: s = '{3'd4, 7'd14};
      6'd43: s = '{3'd3, 7'd5};
      6'd44: s = '{3'd4, 7'd2};
      6'd45: s = '{3'd2, 7'd3};
      6'd46: s = '{3'd2, 7'd1};
      6'd47: s = '{3'd3, 7'd7};
      6'd48: s = '{3'd4, 7'd6};
      6'd49: s = '{3'd4, 7'd11};
      6'd50: s = '{3'd3, 7'd2};
      6'd51: s = '{3'd3, 7'd0};
      6'd52: s = '{3'd1, 7'd1};
      6'd53: s = '{3'd3, 7'd4};
      6'd54: s = '{3'd4, 7'd8};
      6'd55: s = '{3'd3, 7'd6};
      6'd56: s = '{3'd4, 7'd9};
      6'd57: s = '{3'd4, 7'd13};
      6'd58: s = '{3'd4, 7'd3};
      default: s = '{3'd0, 7'd0};
    endcase
    return s;
  endfunction

endpackage

FILE: design/mck_datapath.sv
// keyer datapath: config registers, symbol lookup, element shifter and output register
module mck_datapath (
  input  logic                               clk,
  input  logic                               rst,
  input  logic                               cfg_write,
  input  logic [mck_pkg::CFG_IDX_W-1:0]      cfg_index,
  input  logic [mck_pkg::CFG_DATA_W-1:0]     cfg_data,
  input  logic [mck_pkg::CHAR_W-1:0]         char_code,
  input  mck_pkg::cmd_t                      cmd,
  output mck_pkg::status_t                   status,
  output logic [mck_pkg::FREQ_W-1:0]         segment_frequency,
  output logic [mck_pkg::DUR_W-1:0]          segment_duration,
  output logic                               last_segment
);

  logic [mck_pkg::WPM_W-1:0]     wpm;
  logic [mck_pkg::FREQ_W-1:0]    tone;
  logic [mck_pkg::DOT_W-1:0]     dot;
  logic [mck_pkg::COUNT_W-1:0]   count;
  logic [mck_pkg::PATTERN_W-1:0] pattern;

  logic [mck_pkg::CHAR_W-1:0]    folded;
  logic [mck_pkg::CHAR_W-1:0]    rom_offset;
  mck_pkg::symbol_t              sym;
  logic [mck_pkg::DUR_W-1:0]     dot_ext;
  logic [mck_pkg::DUR_W-1:0]     dur_sel;
  logic [mck_pkg::COUNT_W-1:0]   count_next;

  always_comb begin
    if (char_code >= mck_pkg::CHAR_LOWER_A && char_code <= mck_pkg::CHAR_LOWER_Z) begin
      folded = char_code - mck_pkg::CASE_OFFSET;
    end else begin
      folded = char_code;
    end
  end

  assign rom_offset = folded - mck_pkg::ROM_BASE;
  assign sym        = mck_pkg::symbol_lookup(rom_offset[mck_pkg::ROM_IDX_W-1:0]);
  assign count_next = count - 1'b1;

  assign status.code_ok        = (folded >= mck_pkg::CHAR_SPACE) &&
                                 (folded <= mck_pkg::CHAR_UPPER_Z);
  assign status.is_space       = (folded == mck_pkg::CHAR_SPACE);
  assign status.new_count_zero = (sym.count == '0);
  assign status.count_one      = (count == mck_pkg::COUNT_W'(1));

  assign dot_ext = mck_pkg::DUR_W'(dot);

  always_comb begin
    case (cmd.kind)
      mck_pkg::SEG_TONE: dur_sel = pattern[0] ? mck_pkg::DUR_W'(3 * dot_ext) : dot_ext;
      mck_pkg::SEG_GAP:  dur_sel = dot_ext;
      mck_pkg::SEG_END:  dur_sel = mck_pkg::DUR_W'(3 * dot_ext);
      default:           dur_sel = mck_pkg::DUR_W'(7 * dot_ext);
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wpm  <= mck_pkg::WPM_RESET;
      tone <= mck_pkg::TONE_RESET;
    end else if (cfg_write) begin
      unique case (cfg_index)
        mck_pkg::REG_WPM:  wpm  <= cfg_data[mck_pkg::WPM_W-1:0];
        mck_pkg::REG_TONE: tone <= cfg_data;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load_char) begin
      dot     <= mck_pkg::dot_time(wpm);
      count   <= sym.count;
      pattern <= sym.pattern;
    end else if (cmd.advance) begin
      count   <= count_next;
      pattern <= pattern >> 1;
    end
    if (cmd.load_seg) begin
      segment_frequency <= (cmd.kind == mck_pkg::SEG_TONE) ? tone : '0;
      segment_duration  <= dur_sel;
      last_segment      <= (cmd.kind == mck_pkg::SEG_END) || (cmd.kind == mck_pkg::SEG_WORD);
    end
  end

endmodule

FILE: design/mck_ctrl.sv
// keyer controller: segment sequencing and handshake control
module mck_ctrl (
  input  logic              clk,
  input  logic              rst,
  input  logic              in_valid,
  output logic              in_ready,
  output logic              out_valid,
  input  logic              out_ready,
  input  mck_pkg::status_t  status,
  output mck_pkg::cmd_t     cmd
);

  typedef enum logic [2:0] {
    S_IDLE,
    S_TONE,
    S_GAP,
    S_END,
    S_WORD
  } state_t;

  state_t state;
  state_t state_next;
  logic   accept;
  logic   slot_free;

  assign in_ready  = (state == S_IDLE);
  assign accept    = in_valid && in_ready;
  assign slot_free = !out_valid || out_ready;

  always_comb begin
    cmd.load_char = accept;
    cmd.load_seg  = 1'b0;
    cmd.advance   = 1'b0;
    cmd.kind      = mck_pkg::SEG_TONE;
    state_next    = state;
    unique case (state)
      S_IDLE: begin
        if (accept && status.code_ok) begin
          if (status.is_space) begin
            state_next = S_WORD;
          end else if (status.new_count_zero) begin
            state_next = S_END;
          end else begin
            state_next = S_TONE;
          end
        end
      end
      S_TONE: begin
        cmd.kind = mck_pkg::SEG_TONE;
        if (slot_free) begin
          cmd.load_seg = 1'b1;
          state_next   = S_GAP;
        end
      end
      S_GAP: begin
        cmd.kind = mck_pkg::SEG_GAP;
        if (slot_free) begin
          cmd.load_seg = 1'b1;
          cmd.advance  = 1'b1;
          state_next   = status.count_one ? S_END : S_TONE;
        end
      end
      S_END: begin
        cmd.kind = mck_pkg::SEG_END;
        if (slot_free) begin
          cmd.load_seg = 1'b1;
          state_next   = S_IDLE;
        end
      end
      S_WORD: begin
        cmd.kind = mck_pkg::SEG_WORD;
        if (slot_free) begin
          cmd.load_seg = 1'b1;
          state_next   = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      out_valid <= 1'b0;
    end else begin
      state <= state_next;
      if (cmd.load_seg) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

endmodule

FILE: design/morse_code_keyer.sv
// top level of the morse code keyer
// first word: leaves idle on accept, then is registered once the output slot is free
// throughput: one segment word per cycle while out_ready holds; a character of n elements
//   gives 2n+1 words and a space one; a new character is taken only back in idle
// codes outside space..'Z' after case folding are accepted and give no word
// reset: synchronous; speed returns to 20 wpm, tone to 800 Hz, out_valid clears
module morse_code_keyer (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           in_valid,
  output logic                           in_ready,
  input  logic [mck_pkg::CHAR_W-1:0]     char_code,
  output logic                           out_valid,
  input  logic                           out_ready,
  output logic [mck_pkg::FREQ_W-1:0]     segment_frequency,
  output logic [mck_pkg::DUR_W-1:0]      segment_duration,
  output logic                           last_segment,
  input  logic                           cfg_valid,
  output logic                           cfg_ready,
  input  logic [mck_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [mck_pkg::CFG_DATA_W-1:0] cfg_data
);

  mck_pkg::cmd_t    cmd;
  mck_pkg::status_t status;

  assign cfg_ready = 1'b1;

  mck_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .status    (status),
    .cmd       (cmd)
  );

  mck_datapath u_datapath (
    .clk               (clk),
    .rst               (rst),
    .cfg_write         (cfg_valid && cfg_ready),
    .cfg_index         (cfg_index),
    .cfg_data          (cfg_data),
    .char_code         (char_code),
    .cmd               (cmd),
    .status            (status),
    .segment_frequency (segment_frequency),
    .segment_duration  (segment_duration),
    .last_segment      (last_segment)
  );

endmodule

FILE: verif/morse_code_keyer_test.sv
// self-checking testbench of the morse code keyer: predicts key segments per character
module morse_code_keyer_test;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned DOT_SCALE_MS = 900;
  localparam int unsigned DASH_DOTS = 3;
  localparam int unsigned CLOSE_DOTS = 3;
  localparam int unsigned SPACE_DOTS = 7;
  localparam int unsigned WPM_SLOWEST = 5;
  localparam int unsigned WPM_FASTEST = 20;
  localparam int unsigned SETTLE_CYCLES = 8;
  localparam int unsigned HOLD_OFF_CYCLES = 300;
  localparam int unsigned PHASE_CHARS = 8;

  typedef struct packed {
    logic [mck_pkg::FREQ_W-1:0] freq;
    logic [mck_pkg::DUR_W-1:0]  dur;
    logic                       last;
  } segment_t;

  typedef struct packed {
    logic [2:0] len;
    logic [6:0] bits;
  } morse_code_t;

  logic                            clk = 1'b0;
  logic                            rst = 1'b1;
  logic                            in_valid = 1'b0;
  logic                            in_ready;
  logic [mck_pkg::CHAR_W-1:0]      char_code = '0;
  logic                            out_valid;
  logic                            out_ready = 1'b0;
  logic [mck_pkg::FREQ_W-1:0]      segment_frequency;
  logic [mck_pkg::DUR_W-1:0]       segment_duration;
  logic                            last_segment;
  logic                            cfg_valid = 1'b0;
  logic                            cfg_ready;
  logic [mck_pkg::CFG_IDX_W-1:0]   cfg_index = '0;
  logic [mck_pkg::CFG_DATA_W-1:0]  cfg_data = '0;

  segment_t                   segment_q[$];
  logic [mck_pkg::WPM_W-1:0]  speed_reg = mck_pkg::WPM_RESET;
  logic [mck_pkg::FREQ_W-1:0] tone_reg = mck_pkg::TONE_RESET;
  int unsigned                errors = 0;
  int unsigned                keyed_chars = 0;
  int unsigned                send_idle_pct = 0;
  int unsigned                stall_pct = 0;
  int unsigned                hold_left = 0;

  morse_code_keyer u_top (
    .clk               (clk),
    .rst               (rst),
    .in_valid          (in_valid),
    .in_ready          (in_ready),
    .char_code         (char_code),
    .out_valid         (out_valid),
    .out_ready         (out_ready),
    .segment_frequency (segment_frequency),
    .segment_duration  (segment_duration),
    .last_segment      (last_segment),
    .cfg_valid         (cfg_valid),
    .cfg_ready         (cfg_ready),
    .cfg_index         (cfg_index),
    .cfg_data          (cfg_data)
  );

  initial begin
    forever #2 clk = ~clk;
  end

  initial begin
    #2ms;
    $display("morse_code_keyer_test: errors");
    $finish;
  end

  // element count and pattern, lsb first, set bit is a dash
  function automatic morse_code_t morse_lookup(input logic [7:0] ch);
    morse_code_t m;
    case (ch)
      "\"": m = {3'd6, 7'd18};
      "$":  m = {3'd7, 7'd72};
      "'":  m = {3'd6, 7'd30};
      "(":  m = {3'd5, 7'd13};
      ")":  m = {3'd6, 7'd29};
      "+":  m = {3'd5, 7'd10};
      ",":  m = {3'd6, 7'd51};
      "-":  m = {3'd6, 7'd33};
      ".":  m = {3'd6, 7'd42};
      "/":  m = {3'd5, 7'd9};
      "0":  m = {3'd5, 7'd31};
      "1":  m = {3'd5, 7'd30};
      "2":  m = {3'd5, 7'd28};
      "3":  m = {3'd5, 7'd24};
      "4":  m = {3'd5, 7'd16};
      "5":  m = {3'd5, 7'd0};
      "6":  m = {3'd5, 7'd1};
      "7":  m = {3'd5, 7'd3};
      "8":  m = {3'd5, 7'd7};
      "9":  m = {3'd5, 7'd15};
      ":":  m = {3'd6, 7'd7};
      ";":  m = {3'd6, 7'd21};
      "=":  m = {3'd5, 7'd33};
      "?":  m = {3'd6, 7'd12};
      "A":  m = {3'd2, 7'd2};
      "B":  m = {3'd4, 7'd1};
      "C":  m = {3'd4, 7'd5};
      "D":  m = {3'd3, 7'd1};
      "E":  m = {3'd1, 7'd0};
      "F":  m = {3'd4, 7'd4};
      "G":  m = {3'd3, 7'd3};
      "H":  m = {3'd4, 7'd0};
      "I":  m = {3'd2, 7'd0};
      "J":  m = {3'd4, 7'd14};
      "K":  m = {3'd3, 7'd5};
      "L":  m = {3'd4, 7'd2};
      "M":  m = {3'd2, 7'd3};
      "N":  m = {3'd2, 7'd1};
      "O":  m = {3'd3, 7'd7};
      "P":  m = {3'd4, 7'd6};
      "Q":  m = {3'd4, 7'd11};
      "R":  m = {3'd3, 7'd2};
      "S":  m = {3'd3, 7'd0};
      "T":  m = {3'd1, 7'd1};
      "U":  m = {3'd3, 7'd4};
      "V":  m = {3'd4, 7'd8};
      "W":  m = {3'd3, 7'd6};
      "X":  m = {3'd4, 7'd9};
      "Y":  m = {3'd4, 7'd13};
      "Z":  m = {3'd4, 7'd3};
      default: m = '0;
    endcase
    return m;
  endfunction

  function automatic segment_t key_seg(input int unsigned f, input int unsigned d,
                                       input logic l);
    segment_t s;
    s.freq = f[mck_pkg::FREQ_W-1:0];
    s.dur  = d[mck_pkg::DUR_W-1:0];
    s.last = l;
    return s;
  endfunction

  task automatic expect_segments(input logic [7:0] code);
    int unsigned wpm;
    int unsigned dot;
    logic [7:0]  c;
    morse_code_t m;
    logic [6:0]  bits;
    wpm = speed_reg;
    if (wpm < WPM_SLOWEST) wpm = WPM_SLOWEST;
    if (wpm > WPM_FASTEST) wpm = WPM_FASTEST;
    dot = DOT_SCALE_MS / wpm;
    c = code;
    if (c >= mck_pkg::CHAR_LOWER_A && c <= mck_pkg::CHAR_LOWER_Z) c = c - mck_pkg::CASE_OFFSET;
    if (c > mck_pkg::CHAR_UPPER_Z || c < mck_pkg::CHAR_SPACE) return;
    keyed_chars++;
    if (c == mck_pkg::CHAR_SPACE) begin
      segment_q.push_back(key_seg(0, SPACE_DOTS * dot, 1'b1));
      return;
    end
    m = morse_lookup(c);
    bits = m.bits;
    repeat (m.len) begin
      segment_q.push_back(key_seg(tone_reg, bits[0] ? DASH_DOTS * dot : dot, 1'b0));
      segment_q.push_back(key_seg(0, dot, 1'b0));
      bits = bits >> 1;
    end
    segment_q.push_back(key_seg(0, CLOSE_DOTS * dot, 1'b1));
  endtask

  always @(negedge clk) begin
    if (hold_left > 0) begin
      hold_left--;
      out_ready <= 1'b0;
    end else begin
      out_ready <= ($urandom_range(99) >= stall_pct);
    end
  end

  always @(posedge clk) begin : check_words
    segment_t want;
    if (!rst && out_valid && out_ready) begin
      if (segment_q.size() == 0) begin
        $error("unexpected word: freq %0d dur %0d last %0d",
               segment_frequency, segment_duration, last_segment);
        errors++;
      end else begin
        want = segment_q.pop_front();
        if (segment_frequency !== want.freq) begin
          $error("segment_frequency: expected %0d, actual %0d", want.freq, segment_frequency);
          errors++;
        end
        if (segment_duration !== want.dur) begin
          $error("segment_duration: expected %0d, actual %0d", want.dur, segment_duration);
          errors++;
        end
        if (last_segment !== want.last) begin
          $error("last_segment: expected %0d, actual %0d", want.last, last_segment);
          errors++;
        end
      end
    end
  end

  task automatic send_char(input logic [7:0] c);
    if ($urandom_range(99) < send_idle_pct) begin
      @(negedge clk);
      in_valid <= 1'b0;
      char_code <= 8'($urandom_range(255));
      while ($urandom_range(99) < send_idle_pct) @(negedge clk);
    end
    @(negedge clk);
    in_valid <= 1'b1;
    char_code <= c;
    do @(posedge clk); while (!in_ready);
    expect_segments(c);
  endtask

  task automatic wait_idle();
    @(negedge clk);
    in_valid <= 1'b0;
    while (segment_q.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_reg(input logic [mck_pkg::CFG_IDX_W-1:0] idx,
                           input logic [mck_pkg::CFG_DATA_W-1:0] value);
    @(negedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= value;
    do @(posedge clk); while (!cfg_ready);
    if (idx == mck_pkg::REG_WPM) speed_reg = value[mck_pkg::WPM_W-1:0];
    else tone_reg = value;
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  task automatic set_speed(input logic [mck_pkg::WPM_W-1:0] wpm);
    write_reg(mck_pkg::REG_WPM, {7'($urandom), wpm});
  endtask

  function automatic logic [7:0] random_char();
    int unsigned r;
    r = $urandom_range(99);
    if (r < 15) return 8'($urandom_range(255));
    if (r < 35) return mck_pkg::CHAR_LOWER_A + 8'($urandom_range(25));
    if (r < 55) return mck_pkg::CHAR_SPACE + 8'($urandom_range(32));
    return mck_pkg::CHAR_UPPER_Z - 8'($urandom_range(25));
  endfunction

  task automatic test_directed();
    string       text;
    logic [55:0] dropped;
    text = "ETA$ !azZ09?=\"m";
    dropped = {8'h00, 8'hFF, 8'h7B, 8'h60, 8'h5B, 8'h1F, 8'h80};
    send_idle_pct = 0;
    stall_pct = 0;
    for (int i = 0; i < text.len(); i++) send_char(text[i]);
    for (int i = 0; i < 7; i++) send_char(dropped[8*i +: 8]);
    send_char("Q");
    wait_idle();
  endtask

  task automatic test_speed_and_tone();
    logic [54:0] speeds;
    logic [11:0] tone;
    speeds = {5'd0, 5'd1, 5'd4, 5'd5, 5'd6, 5'd7, 5'd13, 5'd19, 5'd20, 5'd21, 5'd31};
    for (int i = 0; i < 11; i++) begin
      case (i)
        0:       tone = 12'd0;
        1:       tone = 12'hFFF;
        2:       tone = 12'd300;
        3:       tone = 12'd3000;
        default: tone = 12'($urandom_range(4095));
      endcase
      set_speed(speeds[5*i +: 5]);
      write_reg(mck_pkg::REG_TONE, tone);
      send_char("$");
      send_char(" ");
      wait_idle();
    end
  endtask

  task automatic test_output_stall();
    send_idle_pct = 0;
    stall_pct = 0;
    hold_left = HOLD_OFF_CYCLES;
    for (int i = 0; i < 12; i++) send_char(i % 3 == 0 ? "$" : random_char());
    wait_idle();
  endtask

  task automatic test_sender_pause();
    send_idle_pct = 0;
    stall_pct = 48;
    for (int i = 0; i < 5; i++) send_char(random_char());
    wait_idle();
    for (int i = 0; i < 5; i++) send_char(random_char());
    wait_idle();
  endtask

  task automatic test_random();
    int unsigned target;
    for (int phase = 0; phase < 4; phase++) begin
      case (phase)
        0:       begin send_idle_pct = 0;  stall_pct = 0;  end
        1:       begin send_idle_pct = 48; stall_pct = 0;  end
        2:       begin send_idle_pct = 0;  stall_pct = 48; end
        default: begin send_idle_pct = 16; stall_pct = 16; end
      endcase
      set_speed(5'($urandom_range(31)));
      write_reg(mck_pkg::REG_TONE, $urandom_range(3) == 0 ? 12'($urandom_range(4095))
                                                          : 12'($urandom_range(3000, 300)));
      target = keyed_chars + PHASE_CHARS;
      while (keyed_chars < target) send_char(random_char());
      wait_idle();
    end
  endtask

  initial begin
    repeat (11) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    test_directed();
    test_speed_and_tone();
    test_output_stall();
    test_sender_pause();
    test_random();
    wait_idle();
    repeat (20) @(posedge clk);
    if (errors == 0 && segment_q.size() == 0) begin
      $display("morse_code_keyer_test: clean");
    end else begin
      $display("morse_code_keyer_test: errors");
    end
    $finish;
  end

endmodule
